### design/multichannel_adpcm_stereo_mixer_macros.svh
// Assertion macros for the mixer's top-level RTL file.
`ifndef MULTICHANNEL_ADPCM_STEREO_MIXER_MACROS_SVH
`define MULTICHANNEL_ADPCM_STEREO_MIXER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAMIX_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mixer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MAMIX_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mixer assertion failed");

`endif

### design/mamix_pkg.sv
// Types, constants and the step-size factor table of the ADPCM stereo mixer.
package mamix_pkg;

   localparam int CHANNELS_DEF  = 4;
   localparam int CH_MAX        = 4;
   localparam int CH_MAX_W      = 2;

   localparam int BYTE_W        = 8;
   localparam int NIB_W         = 4;
   localparam int VOL_W         = 8;
   localparam int CSR_W         = 16;
   localparam int CSR_IDX_W     = 2;
   localparam int SAMPLE_W      = 16;
   localparam int SCALE_W       = 11;
   localparam int FACTOR_W      = 8;
   localparam int ACC_W         = 18;

   localparam int MUL_A_W       = 18;
   localparam int MUL_B_W       = 11;
   localparam int PROD_W        = MUL_A_W + MUL_B_W + 1;

   localparam logic [SCALE_W-1:0] SCALE_MIN     = 11'd1;
   localparam logic [SCALE_W-1:0] SCALE_MAX     = 11'd2000;
   localparam logic [SCALE_W-1:0] SCALE_RESTART = 11'd10;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_channel0;
      logic [BYTE_W-1:0] byte_channel1;
      logic [BYTE_W-1:0] byte_channel2;
      logic [BYTE_W-1:0] byte_channel3;
      logic [CH_MAX-1:0] active_mask;
      logic [CH_MAX-1:0] restart_mask;
   } mamix_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic                       last;
   } mamix_rsp_type;

   // Operands handed to the shared multiplier: a is signed, b is unsigned.
   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic        [MUL_B_W-1:0] b;
   } mamix_mul_req_type;

   // Step-size factor in 64ths, indexed by the raw 4-bit code.
   function automatic logic [FACTOR_W-1:0] factor_of(input logic [NIB_W-1:0] nib);
      logic [FACTOR_W-1:0] f;
      unique case (nib)
         4'd7, 4'd8, 4'd9:        f = 8'd154;
         4'd6, 4'd10:             f = 8'd128;
         4'd5, 4'd11:             f = 8'd102;
         4'd4, 4'd12:             f = 8'd77;
         default:                 f = 8'd58;
      endcase
      return f;
   endfunction

endpackage

### design/mamix_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
module mamix_mul (
   input  logic                                  clock,
   input  mamix_pkg::mamix_mul_req_type          mul_req,
   output logic signed [mamix_pkg::PROD_W-1:0]   prod
);
   import mamix_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_req.a * $signed({1'b0, mul_req.b}));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### design/multichannel_adpcm_stereo_mixer.sv
// Top level: sequencer around a shared multiplier that decodes and mixes ADPCM channels.
//
//  channel | ports                              | role
//  --------+------------------------------------+------------------------------------
//  req     | req_valid, req_ready, req_data     | one byte per channel plus masks
//  rsp     | rsp_valid, rsp_ready, rsp_data     | two stereo samples per transaction
//  csr     | csr_wr_en, csr_index, csr_wdata    | per-channel left/right volumes
//
// An accepted transaction visits S_CHAN for each channel and the nibble states for both
// nibbles of each active channel, then loads its results in S_DONE; each decoded nibble
// passes through S_DELTA, S_SCALE, S_VL, S_VR and S_ACC, four of which use the multiplier.
// Both results go to a two-entry output buffer, so the next transaction is accepted while
// they wait; results are loaded only once the buffer has drained.
// Reset is synchronous and clears predictors to 0, step sizes to 10 and volumes to 0.
// A stalled rsp_ready holds the buffer; the sequencer then waits in its final state.
module multichannel_adpcm_stereo_mixer #(
   parameter int CHANNELS = mamix_pkg::CHANNELS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  mamix_pkg::mamix_req_type              req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output mamix_pkg::mamix_rsp_type              rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [mamix_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mamix_pkg::CSR_W-1:0]           csr_wdata
);
   import mamix_pkg::*;
   `include "multichannel_adpcm_stereo_mixer_macros.svh"

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_CHAN, S_DELTA, S_SCALE, S_VL, S_VR, S_ACC, S_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [CH_W-1:0]            ch_ff, ch_in;
   logic                       k_ff, k_in;
   mamix_req_type              item_ff, item_in;
   logic signed [SAMPLE_W-1:0] pred_ff  [CHANNELS];
   logic signed [SAMPLE_W-1:0] pred_in  [CHANNELS];
   logic [SCALE_W-1:0]         scale_ff [CHANNELS];
   logic [SCALE_W-1:0]         scale_in [CHANNELS];
   logic [CSR_W-1:0]           vol_ff   [CHANNELS];
   logic [CSR_W-1:0]           vol_in   [CHANNELS];
   logic signed [ACC_W-1:0]    accl_ff  [2];
   logic signed [ACC_W-1:0]    accl_in  [2];
   logic signed [ACC_W-1:0]    accr_ff  [2];
   logic signed [ACC_W-1:0]    accr_in  [2];
   mamix_rsp_type              out_ff   [2];
   mamix_rsp_type              out_in   [2];
   logic [1:0]                 out_cnt_ff, out_cnt_in;

   mamix_mul_req_type          mul_req;
   logic signed [PROD_W-1:0]   prod;

   logic [CH_MAX-1:0][BYTE_W-1:0] byte_vec;
   logic [CH_MAX_W-1:0]        ch_idx;
   logic [BYTE_W-1:0]          byte_sel;
   logic [NIB_W-1:0]           nib;
   logic [NIB_W-1:0]           mag;
   logic                       step_neg;
   logic signed [SAMPLE_W-1:0] cur_pred;
   logic [SCALE_W-1:0]         cur_scale;
   logic [CSR_W-1:0]           cur_vol;
   logic [SAMPLE_W-1:0]        delta;
   logic signed [ACC_W-1:0]    pred_sum;
   logic [12:0]                scale_raw;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // Division by 256 that truncates toward zero.
   function automatic logic signed [SAMPLE_W-1:0] div256(input logic signed [23:0] p);
      logic signed [23:0] t;
      t = p + (p[23] ? 24'sd255 : 24'sd0);
      return t[23:8];
   endfunction

   mamix_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   assign byte_vec  = {item_ff.byte_channel3, item_ff.byte_channel2,
                       item_ff.byte_channel1, item_ff.byte_channel0};
   assign ch_idx    = CH_MAX_W'(ch_ff);
   assign byte_sel  = byte_vec[ch_idx];
   assign nib       = k_ff ? byte_sel[3:0] : byte_sel[7:4];
   assign mag       = nib[3] ? NIB_W'(-nib) : nib;
   assign step_neg  = nib[3] || (nib == 4'd0);
   assign cur_pred  = pred_ff[ch_ff];
   assign cur_scale = scale_ff[ch_ff];
   assign cur_vol   = vol_ff[ch_ff];
   assign delta     = prod[SAMPLE_W:1];
   assign pred_sum  = ACC_W'(cur_pred) +
                      (step_neg ? -$signed({2'b00, delta}) : $signed({2'b00, delta}));
   assign scale_raw = prod[18:6];

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (out_cnt_ff != 2'd0);
   assign rsp_data  = (out_cnt_ff == 2'd2) ? out_ff[0] : out_ff[1];

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_req.a = '0;
      mul_req.b = '0;
      unique case (state_ff)
         S_DELTA: begin
            mul_req.a = MUL_A_W'({mag, 1'b1});
            mul_req.b = cur_scale;
         end
         S_SCALE: begin
            mul_req.a = MUL_A_W'(factor_of(nib));
            mul_req.b = cur_scale;
         end
         S_VL: begin
            mul_req.a = MUL_A_W'(cur_pred);
            mul_req.b = MUL_B_W'(cur_vol[15:8]);
         end
         S_VR: begin
            mul_req.a = MUL_A_W'(cur_pred);
            mul_req.b = MUL_B_W'(cur_vol[7:0]);
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      ch_in      = ch_ff;
      k_in       = k_ff;
      item_in    = item_ff;
      pred_in    = pred_ff;
      scale_in   = scale_ff;
      vol_in     = vol_ff;
      accl_in    = accl_ff;
      accr_in    = accr_ff;
      out_in     = out_ff;
      out_cnt_in = out_cnt_ff;

      if (rsp_valid && rsp_ready) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end

      if (csr_wr_en && (32'(csr_index) < CHANNELS)) begin
         vol_in[CH_W'(csr_index)] = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               ch_in   = '0;
               k_in    = 1'b0;
               for (int i = 0; i < 2; i++) begin
                  accl_in[i] = '0;
                  accr_in[i] = '0;
               end
               for (int i = 0; i < CHANNELS; i++) begin
                  if (req_data.restart_mask[i]) begin
                     pred_in[i]  = '0;
                     scale_in[i] = SCALE_RESTART;
                  end
               end
               state_in = S_CHAN;
            end
         end
         S_CHAN: begin
            k_in = 1'b0;
            if (item_ff.active_mask[ch_idx]) begin
               state_in = S_DELTA;
            end else if (ch_ff == CH_W'(CHANNELS - 1)) begin
               state_in = S_DONE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = S_CHAN;
            end
         end
         S_DELTA: begin
            state_in = S_SCALE;
         end
         S_SCALE: begin
            pred_in[ch_ff] = sat16(pred_sum);
            state_in       = S_VL;
         end
         S_VL: begin
            if (scale_raw < 13'(SCALE_MIN)) begin
               scale_in[ch_ff] = SCALE_MIN;
            end else if (scale_raw > 13'(SCALE_MAX)) begin
               scale_in[ch_ff] = SCALE_MAX;
            end else begin
               scale_in[ch_ff] = scale_raw[SCALE_W-1:0];
            end
            state_in = S_VR;
         end
         S_VR: begin
            accl_in[k_ff] = accl_ff[k_ff] + ACC_W'(div256(prod[23:0]));
            state_in      = S_ACC;
         end
         S_ACC: begin
            accr_in[k_ff] = accr_ff[k_ff] + ACC_W'(div256(prod[23:0]));
            if (!k_ff) begin
               k_in     = 1'b1;
               state_in = S_DELTA;
            end else if (ch_ff == CH_W'(CHANNELS - 1)) begin
               state_in = S_DONE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = S_CHAN;
            end
         end
         S_DONE: begin
            // Load both results only into an empty buffer.
            if (out_cnt_ff == 2'd0) begin
               for (int i = 0; i < 2; i++) begin
                  out_in[i].left_sample  = sat16(accl_ff[i]);
                  out_in[i].right_sample = sat16(accr_ff[i]);
                  out_in[i].last         = (i == 1);
               end
               out_cnt_in = 2'd2;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ch_ff      <= '0;
         k_ff       <= 1'b0;
         out_cnt_ff <= 2'd0;
         for (int i = 0; i < CHANNELS; i++) begin
            pred_ff[i]  <= '0;
            scale_ff[i] <= SCALE_RESTART;
            vol_ff[i]   <= '0;
         end
      end else begin
         state_ff   <= state_in;
         ch_ff      <= ch_in;
         k_ff       <= k_in;
         out_cnt_ff <= out_cnt_in;
         pred_ff    <= pred_in;
         scale_ff   <= scale_in;
         vol_ff     <= vol_in;
      end
      item_ff <= item_in;
      accl_ff <= accl_in;
      accr_ff <= accr_in;
      out_ff  <= out_in;
   end

   `MAMIX_ASSERT_NXT(a_load_fills_buffer, clock, reset,
      (state_ff == S_DONE) && (out_cnt_ff == 2'd0), out_cnt_ff == 2'd2)
   `MAMIX_ASSERT_NXT(a_second_is_last, clock, reset,
      rsp_valid && rsp_ready && (out_cnt_ff == 2'd2), rsp_valid && rsp_data.last)
   `MAMIX_ASSERT_IMP(a_scale_in_range, clock, reset,
      state_ff == S_DELTA, (cur_scale >= SCALE_MIN) && (cur_scale <= SCALE_MAX))
   `MAMIX_ASSERT_NXT(a_busy_after_accept, clock, reset,
      req_valid && req_ready, !req_ready)

endmodule

### tb/tb_multichannel_adpcm_stereo_mixer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the four-channel ADPCM decoder and stereo mixer.
module tb_multichannel_adpcm_stereo_mixer;
   import mamix_pkg::*;

   localparam int SETTLE_CYCLES  = 64;
   localparam int LONG_HOLD      = 400;
   localparam int SEGMENTS       = 6;
   localparam int SEGMENT_FRAMES = 250;
   localparam int LOUD_ROW       = 4;
   localparam int LIMIT_NS       = 4_000_000;
   localparam int SAMPLE_LO      = -32768;
   localparam int SAMPLE_HI      = 32767;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VOLUMES_CH0,
      REG_VOLUMES_CH1,
      REG_VOLUMES_CH2,
      REG_VOLUMES_CH3
   } volume_reg_e;

   typedef struct {
      mamix_req_type frame;
      bit            silent;
   } vector_row_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   mamix_req_type        req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   mamix_rsp_type        rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Decoder state and volumes as the block should hold them.
   int                   mix_pred [4];
   int                   mix_scale [4];
   logic [CSR_W-1:0]     vol_copy [4];

   mamix_rsp_type        expected_mix_q [$];
   vector_row_t          directed_rows [$];

   int                   req_idle_pct = 0;
   int                   rsp_idle_pct = 0;
   int                   hold_requests = 0;
   int                   hold_served = 0;
   int                   hold_left = 0;
   int                   mismatches = 0;
   int                   samples_checked = 0;
   int                   frames_sent = 0;
   int                   volume_settings = 0;

   multichannel_adpcm_stereo_mixer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Step-size growth in 64ths, looked up by the raw 4-bit code.
   function automatic int step_factor(input logic [NIB_W-1:0] code);
      case (code)
         4'd4, 4'd12:       return 77;
         4'd5, 4'd11:       return 102;
         4'd6, 4'd10:       return 128;
         4'd7, 4'd8, 4'd9:  return 154;
         default:           return 58;
      endcase
   endfunction

   function automatic int decode_nibble(input int ch, input logic [NIB_W-1:0] code);
      int stp;
      int mag;
      int dlt;
      stp = code[3] ? int'(code) - 16 : int'(code);
      mag = (stp < 0) ? -stp : stp;
      dlt = ((1 + 2 * mag) * mix_scale[ch]) / 2;
      // A zero step still moves the predictor downward.
      if (stp <= 0) dlt = -dlt;
      mix_pred[ch] = clamp_int(mix_pred[ch] + dlt, SAMPLE_LO, SAMPLE_HI);
      mix_scale[ch] = clamp_int((mix_scale[ch] * step_factor(code)) / 64,
                                int'(SCALE_MIN), int'(SCALE_MAX));
      return mix_pred[ch];
   endfunction

   function automatic void predict_mix(input mamix_req_type f,
                                       output mamix_rsp_type hi_half,
                                       output mamix_rsp_type lo_half);
      int               acc_l [2];
      int               acc_r [2];
      logic [BYTE_W-1:0] frame_byte [4];
      int               vl;
      int               vr;
      int               s;
      logic [NIB_W-1:0] code;
      frame_byte[0] = f.byte_channel0;
      frame_byte[1] = f.byte_channel1;
      frame_byte[2] = f.byte_channel2;
      frame_byte[3] = f.byte_channel3;
      for (int k = 0; k < 2; k++) begin
         acc_l[k] = 0;
         acc_r[k] = 0;
      end
      for (int ch = 0; ch < CH_MAX; ch++) begin
         vl = vol_copy[ch][15:8];
         vr = vol_copy[ch][7:0];
         if (f.restart_mask[ch]) begin
            mix_pred[ch] = 0;
            mix_scale[ch] = SCALE_RESTART;
         end
         if (f.active_mask[ch]) begin
            for (int k = 0; k < 2; k++) begin
               code = (k == 0) ? frame_byte[ch][7:4] : frame_byte[ch][3:0];
               s = decode_nibble(ch, code);
               acc_l[k] += (s * vl) / 256;
               acc_r[k] += (s * vr) / 256;
            end
         end
      end
      hi_half.left_sample  = 16'(clamp_int(acc_l[0], SAMPLE_LO, SAMPLE_HI));
      hi_half.right_sample = 16'(clamp_int(acc_r[0], SAMPLE_LO, SAMPLE_HI));
      hi_half.last         = 1'b0;
      lo_half.left_sample  = 16'(clamp_int(acc_l[1], SAMPLE_LO, SAMPLE_HI));
      lo_half.right_sample = 16'(clamp_int(acc_r[1], SAMPLE_LO, SAMPLE_HI));
      lo_half.last         = 1'b1;
   endfunction

   function automatic void add_row(input logic [7:0] b0, input logic [7:0] b1,
                                   input logic [7:0] b2, input logic [7:0] b3,
                                   input logic [3:0] act, input logic [3:0] rst,
                                   input bit silent);
      vector_row_t row;
      row.frame = {b0, b1, b2, b3, act, rst};
      row.silent = silent;
      directed_rows.push_back(row);
   endfunction

   // Runs of full-scale codes push predictors and the mix into saturation.
   function automatic logic [7:0] adpcm_byte();
      int r;
      r = $urandom_range(99);
      if (r < 15)
         return {($urandom_range(1) != 0) ? 4'h7 : 4'h8,
                 ($urandom_range(1) != 0) ? 4'h7 : 4'h8};
      if (r < 20) return 8'h00;
      return 8'($urandom_range(255));
   endfunction

   function automatic mamix_req_type random_frame();
      mamix_req_type f;
      f.byte_channel0 = adpcm_byte();
      f.byte_channel1 = adpcm_byte();
      f.byte_channel2 = adpcm_byte();
      f.byte_channel3 = adpcm_byte();
      f.active_mask  = ($urandom_range(99) < 70) ? 4'hF : 4'($urandom_range(15));
      f.restart_mask = ($urandom_range(99) < 92) ? 4'h0 : 4'($urandom_range(15));
      return f;
   endfunction

   task automatic offer(input mamix_req_type f, input bit silent);
      mamix_rsp_type hi_half;
      mamix_rsp_type lo_half;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= f;
      do @(posedge clock); while (!req_ready);
      predict_mix(f, hi_half, lo_half);
      if (silent) begin
         hi_half.left_sample  = '0;
         hi_half.right_sample = '0;
         lo_half.left_sample  = '0;
         lo_half.right_sample = '0;
      end
      expected_mix_q.push_back(hi_half);
      expected_mix_q.push_back(lo_half);
      frames_sent++;
   endtask

   task automatic drain_mix();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_mix_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input volume_reg_e idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      vol_copy[idx] = val;
   endtask

   task automatic set_volumes(input logic [CSR_W-1:0] v0, input logic [CSR_W-1:0] v1,
                              input logic [CSR_W-1:0] v2, input logic [CSR_W-1:0] v3);
      write_register(REG_VOLUMES_CH0, v0);
      write_register(REG_VOLUMES_CH1, v1);
      write_register(REG_VOLUMES_CH2, v2);
      write_register(REG_VOLUMES_CH3, v3);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      volume_settings++;
   endtask

   // Receiver: random back-pressure plus an occasional long hold.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left = LONG_HOLD;
         hold_served++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      mamix_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_mix_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected stereo sample: L=%0d R=%0d last=%0d",
                        rsp_data.left_sample, rsp_data.right_sample, rsp_data.last);
         end else begin
            want = expected_mix_q.pop_front();
            samples_checked++;
            if (rsp_data.left_sample !== want.left_sample ||
                rsp_data.right_sample !== want.right_sample ||
                rsp_data.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample %0d: expected L=%0d R=%0d last=%0d, got L=%0d R=%0d last=%0d",
                           samples_checked, want.left_sample, want.right_sample, want.last,
                           rsp_data.left_sample, rsp_data.right_sample, rsp_data.last);
            end
         end
      end
   end

   initial begin : stimulus
      for (int ch = 0; ch < CH_MAX; ch++) begin
         mix_pred[ch]  = 0;
         mix_scale[ch] = SCALE_RESTART;
         vol_copy[ch]  = '0;
      end

      // Volumes are still zero for the first rows, so every sample is silent.
      add_row(8'hFF, 8'h00, 8'h80, 8'h7F, 4'hF, 4'h0, 1'b1);
      add_row(8'h12, 8'h34, 8'h56, 8'h78, 4'hF, 4'hF, 1'b1);
      add_row(8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 1'b1);
      add_row(8'h77, 8'h77, 8'h77, 8'h77, 4'h5, 4'hA, 1'b1);
      // Full volume: climb to positive saturation, then fall to negative.
      add_row(8'h77, 8'h77, 8'h77, 8'h77, 4'hF, 4'hF, 1'b0);
      for (int i = 0; i < 6; i++)
         add_row(8'h77, 8'h77, 8'h77, 8'h77, 4'hF, 4'h0, 1'b0);
      for (int i = 0; i < 7; i++)
         add_row(8'h88, 8'h88, 8'h88, 8'h88, 4'hF, 4'h0, 1'b0);
      add_row(8'h00, 8'h00, 8'h00, 8'h00, 4'hF, 4'h0, 1'b0);
      // Restart on idle channels, then nothing active at all.
      add_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'h0, 4'hF, 1'b1);
      add_row(8'h5A, 8'hA5, 8'h3C, 8'hC3, 4'h0, 4'h0, 1'b1);
      add_row(8'hF1, 8'h1F, 8'h90, 8'h09, 4'h6, 4'h9, 1'b0);
      add_row(8'h08, 8'h80, 8'h70, 8'h07, 4'hF, 4'h0, 1'b0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 7;
      rsp_idle_pct = 84;
      foreach (directed_rows[i]) begin
         if (i == LOUD_ROW) begin
            drain_mix();
            set_volumes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         end
         offer(directed_rows[i].frame, directed_rows[i].silent);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_mix();
         case (seg)
            0:       set_volumes(16'hFF00, 16'h00FF, 16'hFFFF, 16'h0000);
            3:       set_volumes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            default: set_volumes(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                 16'($urandom_range(65535)), 16'($urandom_range(65535)));
         endcase
         case (seg / 2)
            0: begin
               req_idle_pct = 7;
               rsp_idle_pct = 84;
            end
            1: begin
               req_idle_pct = 84;
               rsp_idle_pct = 7;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         // With no idling, stall the output long enough to back up the input.
         if (seg == 4) hold_requests++;
         for (int n = 0; n < SEGMENT_FRAMES; n++) begin
            if (seg == 5 && n == SEGMENT_FRAMES / 2) drain_mix();
            offer(random_frame(), 1'b0);
         end
      end

      drain_mix();
      $display("%0d frames sent, %0d stereo samples checked, %0d volume settings applied",
               frames_sent, samples_checked, volume_settings);
      $display("covered silent and full-scale volumes, saturation both ways, restarts, %s",
               "idle channels, three back-pressure mixes and a long output stall");
      if (expected_mix_q.size() != 0)
         $display("%0d expected samples never arrived", expected_mix_q.size());
      if (mismatches == 0 && expected_mix_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("timeout with %0d samples outstanding", expected_mix_q.size());
      $display("simulation failed");
      $finish;
   end

endmodule
